@@ rtl/core/frf_pkg.sv @@
// ----------------------------------------------------------------------------
// frf_pkg
// Shared types and constants of the flood relay filter: word layouts of the
// input and result channels, action codes, register indexes, sequencer states.
// ----------------------------------------------------------------------------
package frf_pkg;

  localparam int UID_W = 32;
  localparam int SEQ_W = 16;
  localparam int TTL_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [UID_W-1:0] BROADCAST_UID = 32'hFFFF_FFFF;

  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_UID       = 3'd0,
    CFG_NODE_ROLE     = 3'd1,
    CFG_MAX_TTL       = 3'd2,
    CFG_CACHE_TIMEOUT = 3'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ACT_BAD_CRC   = 3'd0,
    ACT_DUPLICATE = 3'd1,
    ACT_DELIVER   = 3'd2,
    ACT_RELAY     = 3'd3,
    ACT_IGNORED   = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic             op;
    logic             crc_ok;
    logic [UID_W-1:0] source_uid;
    logic [SEQ_W-1:0] seq_num;
    logic [UID_W-1:0] dest_uid;
    logic [TTL_W-1:0] hop_ttl;
    logic [UID_W-1:0] prev_hop_uid;
  } in_word_t;

  typedef struct packed {
    action_t          action;
    logic [TTL_W-1:0] out_ttl;
    logic [UID_W-1:0] out_prev_hop;
    logic [TTL_W-1:0] route_hops;
    logic [UID_W-1:0] route_next_hop;
    logic [UID_W-1:0] dropped_total;
    logic [UID_W-1:0] relayed_total;
  } out_word_t;

endpackage

@@ rtl/core/flood_relay_filter_top.sv @@
// ----------------------------------------------------------------------------
// flood_relay_filter_top
// Duplicate suppression and relay decision for controlled flooding, with a
// ring cache of recently seen (source, sequence) pairs and millisecond aging.
// ----------------------------------------------------------------------------
// Each word is either a packet header or a 1 ms tick. A packet with a good CRC
// and every tick walk the filled cache entries through one memory read port,
// one entry per cycle. A packet with a good CRC goes from the scan state to the
// result state, which loads the output register once it is free. A bad-CRC
// packet skips the scan and goes straight to the result state. A tick keeps
// in_ready low until its walk of the cache is done, and it gives no
// result. The block takes one word at a time; in_ready is high only between
// words. A finished result waits in the output register, so the next word can
// be taken while it is still pending.
// Configuration writes are taken at any cycle and should only be issued while
// the block is idle.
module flood_relay_filter_top #(
  parameter int CACHE_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  frf_pkg::in_word_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output frf_pkg::out_word_t              out_data,
  input  logic                            cfg_we,
  input  logic [frf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [frf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import frf_pkg::*;

  localparam int AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int FW = $clog2(CACHE_DEPTH + 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(CACHE_DEPTH);
  localparam logic [AW-1:0] HEAD_LAST = AW'(CACHE_DEPTH - 1);

  // configuration
  logic [UID_W-1:0] own_uid_r;
  logic [1:0]       node_role_r;
  logic [TTL_W-1:0] max_ttl_r;
  logic [31:0]      timeout_r;

  // control and counters
  state_t           state_r, state_nxt;
  logic [AW-1:0]    ring_head_r;
  logic [FW-1:0]    ring_fill_r;
  logic [31:0]      now_ms_r;
  logic [31:0]      dup_drops_r, dup_drops_nxt;
  logic [31:0]      relays_done_r, relays_done_nxt;
  logic [FW-1:0]    rd_idx_r;
  logic             rd_vld_r;
  logic [AW-1:0]    rd_addr_r;
  logic             hit_r;
  logic             out_valid_r;
  out_word_t        out_data_r;
  in_word_t         in_r;

  // cache memories
  logic [UID_W-1:0] entry_source [CACHE_DEPTH];
  logic [SEQ_W-1:0] entry_seq    [CACHE_DEPTH];
  logic [31:0]      entry_stamp  [CACHE_DEPTH];
  logic [UID_W-1:0] src_q;
  logic [SEQ_W-1:0] seq_q;
  logic [31:0]      stamp_q;

  // sequencer outputs
  logic             accept;
  logic             scan_issue;
  logic             scan_done;
  logic             out_load;
  logic             age_we;
  logic             rem_we;
  out_word_t        result;
  logic             is_hit;
  logic             is_stale;
  logic [31:0]      age;

  assign accept = in_valid && in_ready;
  assign age    = now_ms_r - stamp_q;
  assign is_hit = rd_vld_r && (src_q == in_r.source_uid) && (seq_q == in_r.seq_num);
  assign is_stale = (src_q != '0) && (age > timeout_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.op == OP_PACKET && !in_data.crc_ok) state_nxt = ST_RESULT;
          else state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) state_nxt = (in_r.op == OP_TICK) ? ST_IDLE : ST_RESULT;
      end
      ST_RESULT: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready   = (state_r == ST_IDLE);
    scan_issue = (state_r == ST_SCAN) && (rd_idx_r < ring_fill_r);
    scan_done  = (state_r == ST_SCAN) && !scan_issue && !rd_vld_r;
    out_load   = (state_r == ST_RESULT) && (!out_valid_r || out_ready);
    age_we     = (state_r == ST_SCAN) && rd_vld_r && (in_r.op == OP_TICK) && is_stale;
    rem_we     = out_load && in_r.crc_ok && !hit_r;
  end

  // result word
  always_comb begin
    result          = '0;
    dup_drops_nxt   = dup_drops_r;
    relays_done_nxt = relays_done_r;
    priority if (!in_r.crc_ok) begin
      result.action = ACT_BAD_CRC;
    end else if (hit_r) begin
      result.action = ACT_DUPLICATE;
      dup_drops_nxt = dup_drops_r + 32'd1;
    end else if (in_r.dest_uid == own_uid_r || in_r.dest_uid == BROADCAST_UID) begin
      result.action         = ACT_DELIVER;
      result.route_hops     = max_ttl_r - in_r.hop_ttl + 8'd1;
      result.route_next_hop = in_r.prev_hop_uid;
    end else if (in_r.hop_ttl > 8'd1 && node_role_r != 2'd0) begin
      result.action         = ACT_RELAY;
      result.out_ttl        = in_r.hop_ttl - 8'd1;
      result.out_prev_hop   = own_uid_r;
      result.route_hops     = max_ttl_r - in_r.hop_ttl;
      result.route_next_hop = in_r.prev_hop_uid;
      relays_done_nxt       = relays_done_r + 32'd1;
    end else begin
      result.action = ACT_IGNORED;
    end
    result.dropped_total = dup_drops_nxt;
    result.relayed_total = relays_done_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_uid_r   <= '0;
      node_role_r <= '0;
      max_ttl_r   <= 8'd15;
      timeout_r   <= 32'd30000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_UID:       own_uid_r   <= cfg_wdata;
        CFG_NODE_ROLE:     node_role_r <= cfg_wdata[1:0];
        CFG_MAX_TTL:       max_ttl_r   <= cfg_wdata[TTL_W-1:0];
        CFG_CACHE_TIMEOUT: timeout_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      ring_head_r   <= '0;
      ring_fill_r   <= '0;
      now_ms_r      <= '0;
      dup_drops_r   <= '0;
      relays_done_r <= '0;
      rd_idx_r      <= '0;
      rd_vld_r      <= 1'b0;
      hit_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= scan_issue;
      if (accept) begin
        rd_idx_r <= '0;
        hit_r    <= 1'b0;
        if (in_data.op == OP_TICK) now_ms_r <= now_ms_r + 32'd1;
      end else begin
        if (scan_issue) rd_idx_r <= rd_idx_r + 1'b1;
        if (is_hit && in_r.op == OP_PACKET) hit_r <= 1'b1;
      end
      if (out_load) begin
        dup_drops_r   <= dup_drops_nxt;
        relays_done_r <= relays_done_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (rem_we) begin
        ring_head_r <= (ring_head_r == HEAD_LAST) ? '0 : ring_head_r + 1'b1;
        if (ring_fill_r < FILL_MAX) ring_fill_r <= ring_fill_r + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) in_r <= in_data;
    if (out_load) out_data_r <= result;
    if (scan_issue) rd_addr_r <= rd_idx_r[AW-1:0];
  end

  // cache memories: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (rem_we) begin
      entry_source[ring_head_r] <= in_r.source_uid;
      entry_seq[ring_head_r]    <= in_r.seq_num;
      entry_stamp[ring_head_r]  <= now_ms_r;
    end else if (age_we) begin
      entry_source[rd_addr_r] <= '0;
    end
    if (scan_issue) begin
      src_q   <= entry_source[rd_idx_r[AW-1:0]];
      seq_q   <= entry_seq[rd_idx_r[AW-1:0]];
      stamp_q <= entry_stamp[rd_idx_r[AW-1:0]];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ring_fill_r <= FILL_MAX)
    else $error("cache fill above depth");

  a_head_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (ring_fill_r < FILL_MAX) |-> (ring_head_r == ring_fill_r[AW-1:0]))
    else $error("ring head out of step with fill");

  a_read_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(state_r == ST_SCAN))
    else $error("read data outside a scan");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(age_we && rem_we))
    else $error("aging and insert collide");

  a_relay_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && result.action != ACT_RELAY) |=> $stable(relays_done_r))
    else $error("relay count moved without a relay");

  a_tick_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && in_r.op == OP_TICK) |-> state_nxt != ST_RESULT)
    else $error("tick heading for a result");

endmodule

@@ sim/tb_flood_relay_filter_top.sv @@
// ----------------------------------------------------------------------------
// tb_flood_relay_filter_top
// Self-checking bench for the flood relay filter. Packet headers and 1 ms
// ticks go in on a valid/ready channel. A behavioral copy of the duplicate
// cache, aging clock and relay decision predicts every verdict word, and each
// word from the block is compared field by field. Six phases run, each with
// its own register setting; pairs share an idle pattern; directed words open phase 0.
// ----------------------------------------------------------------------------
module tb_flood_relay_filter_top;
  import frf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH          = 16;
  localparam int N_PHASES       = 6;
  localparam int RAND_PER_PHASE = 288;
  localparam int SETTLE_CYCLES  = DEPTH + 16;
  localparam int STALL_LIMIT    = 2000;
  localparam int RECENT_KEEP    = 32;

  localparam logic [1:0]           ROLE_PLAIN    = 2'd0;
  localparam logic [1:0]           ROLE_RELAY    = 2'd1;
  localparam logic [1:0]           ROLE_GATEWAY  = 2'd2;
  localparam logic [1:0]           ROLE_COORD    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
  localparam logic [UID_W-1:0]     FOREIGN_UID   = 32'h1234_5678;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  flood_relay_filter_top #(.CACHE_DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // behavioral copy of the block's registers and cache
  logic [UID_W-1:0] my_uid = '0;
  logic [1:0]       my_role = ROLE_PLAIN;
  logic [TTL_W-1:0] my_max_ttl = 8'd15;
  logic [31:0]      my_timeout = 32'd30000;

  logic [UID_W-1:0] seen_src[DEPTH];
  logic [SEQ_W-1:0] seen_seq[DEPTH];
  logic [31:0]      seen_stamp[DEPTH];
  int               seen_head = 0;
  int               seen_fill = 0;
  logic [31:0]      clock_ms = '0;
  logic [31:0]      dup_count = '0;
  logic [31:0]      relay_count = '0;

  in_word_t         pending_words[$];
  out_word_t        expected_verdicts[$];
  logic [UID_W-1:0] recent_src[$];
  logic [SEQ_W-1:0] recent_seq[$];

  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  int errors = 0;
  int stall_cycles = 0;

  task automatic decide_word(input in_word_t w, output bit produces, output out_word_t v);
    bit hit;
    int i;
    v = '0;
    produces = 1'b0;
    hit = 1'b0;
    if (w.op == OP_TICK) begin
      clock_ms = clock_ms + 32'd1;
      for (i = 0; i < seen_fill; i++)
        if (seen_src[i] != '0 && (clock_ms - seen_stamp[i]) > my_timeout)
          seen_src[i] = '0;
    end else begin
      produces = 1'b1;
      if (!w.crc_ok) begin
        v.action = ACT_BAD_CRC;
      end else begin
        for (i = 0; i < seen_fill; i++)
          if (seen_src[i] == w.source_uid && seen_seq[i] == w.seq_num)
            hit = 1'b1;
        if (hit) begin
          dup_count = dup_count + 32'd1;
          v.action = ACT_DUPLICATE;
        end else begin
          seen_src[seen_head] = w.source_uid;
          seen_seq[seen_head] = w.seq_num;
          seen_stamp[seen_head] = clock_ms;
          seen_head = (seen_head + 1) % DEPTH;
          if (seen_fill < DEPTH)
            seen_fill++;
          if (w.dest_uid == my_uid || w.dest_uid == BROADCAST_UID) begin
            v.action = ACT_DELIVER;
            v.route_hops = my_max_ttl - w.hop_ttl + 8'd1;
            v.route_next_hop = w.prev_hop_uid;
          end else if (w.hop_ttl > 8'd1 && my_role != ROLE_PLAIN) begin
            relay_count = relay_count + 32'd1;
            v.action = ACT_RELAY;
            v.out_ttl = w.hop_ttl - 8'd1;
            v.out_prev_hop = my_uid;
            v.route_hops = my_max_ttl - w.hop_ttl;
            v.route_next_hop = w.prev_hop_uid;
          end else begin
            v.action = ACT_IGNORED;
          end
        end
      end
      v.dropped_total = dup_count;
      v.relayed_total = relay_count;
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // input side: predict at acceptance, then present the next word
  always @(posedge clk) begin : drive_in
    bit        produces;
    out_word_t verdict;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decide_word(in_data, produces, verdict);
        if (produces)
          expected_verdicts.push_back(verdict);
      end
      if (!in_valid || in_ready) begin
        if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin : watch_out
    out_word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected word, expected none got %h", $time, out_data);
          errors++;
        end else begin
          want = expected_verdicts.pop_front();
          check_field("action", {29'b0, want.action}, {29'b0, out_data.action});
          check_field("out_ttl", {24'b0, want.out_ttl}, {24'b0, out_data.out_ttl});
          check_field("out_prev_hop", want.out_prev_hop, out_data.out_prev_hop);
          check_field("route_hops", {24'b0, want.route_hops}, {24'b0, out_data.route_hops});
          check_field("route_next_hop", want.route_next_hop, out_data.route_next_hop);
          check_field("dropped_total", want.dropped_total, out_data.dropped_total);
          check_field("relayed_total", want.relayed_total, out_data.relayed_total);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("flood_relay_filter_top: mismatch");
        $finish;
      end
    end
  end

  function automatic in_word_t pkt(bit crc, logic [UID_W-1:0] src, logic [SEQ_W-1:0] seq,
                                   logic [UID_W-1:0] dst, logic [TTL_W-1:0] ttl,
                                   logic [UID_W-1:0] prev);
    in_word_t w;
    w.op = OP_PACKET;
    w.crc_ok = crc;
    w.source_uid = src;
    w.seq_num = seq;
    w.dest_uid = dst;
    w.hop_ttl = ttl;
    w.prev_hop_uid = prev;
    return w;
  endfunction

  function automatic in_word_t tick_word();
    in_word_t w;
    w = pkt(1'($urandom), $urandom, SEQ_W'($urandom), $urandom, TTL_W'($urandom), $urandom);
    w.op = OP_TICK;
    return w;
  endfunction

  // mostly good packets; reuse of recent (source, seq) pairs drives duplicates
  function automatic in_word_t rand_word();
    in_word_t w;
    int       pick;
    int       k;
    w = pkt(1'b1, $urandom, SEQ_W'($urandom), $urandom, TTL_W'($urandom), $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      w = tick_word();
    end else begin
      if (pick < 20)
        w.crc_ok = 1'b0;
      pick = $urandom_range(0, 99);
      if (recent_src.size() > 0 && pick < 35) begin
        k = $urandom_range(0, recent_src.size() - 1);
        w.source_uid = recent_src[k];
        w.seq_num = recent_seq[k];
      end else if (recent_src.size() > 0 && pick < 45) begin
        // aged-out entries keep their seq under source zero
        k = $urandom_range(0, recent_src.size() - 1);
        w.source_uid = '0;
        w.seq_num = recent_seq[k];
      end else if (pick < 55) begin
        w.source_uid = $urandom_range(0, 3);
        w.seq_num = SEQ_W'($urandom_range(0, 3));
      end
      recent_src.push_back(w.source_uid);
      recent_seq.push_back(w.seq_num);
      if (recent_src.size() > RECENT_KEEP) begin
        void'(recent_src.pop_front());
        void'(recent_seq.pop_front());
      end
      pick = $urandom_range(0, 99);
      if (pick < 35)
        w.dest_uid = my_uid;
      else if (pick < 50)
        w.dest_uid = BROADCAST_UID;
      else if (pick < 55)
        w.dest_uid = my_uid ^ (32'd1 << $urandom_range(0, 31));
      if ($urandom_range(0, 99) < 25) begin
        case ($urandom_range(0, 3))
          0:       w.hop_ttl = 8'd0;
          1:       w.hop_ttl = 8'd1;
          2:       w.hop_ttl = 8'd2;
          default: w.hop_ttl = 8'hFF;
        endcase
      end
    end
    return w;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_OWN_UID:       my_uid = val;
      CFG_NODE_ROLE:     my_role = val[1:0];
      CFG_MAX_TTL:       my_max_ttl = val[TTL_W-1:0];
      CFG_CACHE_TIMEOUT: my_timeout = val;
      default: ;
    endcase
  endtask

  task automatic program_phase(int p);
    case (p)
      0: begin
        write_reg(CFG_OWN_UID, 32'h0000_00A5);
        write_reg(CFG_NODE_ROLE, CFG_DATA_W'(ROLE_RELAY));
        write_reg(CFG_MAX_TTL, 32'd15);
        write_reg(CFG_CACHE_TIMEOUT, 32'd0);
      end
      1: begin
        write_reg(CFG_OWN_UID, 32'd0);
        write_reg(CFG_NODE_ROLE, CFG_DATA_W'(ROLE_PLAIN));
        write_reg(CFG_MAX_TTL, 32'd1);
        write_reg(CFG_CACHE_TIMEOUT, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_IDX, 32'hFFFF_FFFF);
      end
      2: begin
        write_reg(CFG_OWN_UID, 32'hFFFF_FFFF);
        write_reg(CFG_NODE_ROLE, CFG_DATA_W'(ROLE_GATEWAY));
        write_reg(CFG_MAX_TTL, 32'd255);
        write_reg(CFG_CACHE_TIMEOUT, 32'd3);
      end
      3: begin
        write_reg(CFG_OWN_UID, $urandom);
        write_reg(CFG_NODE_ROLE, CFG_DATA_W'(ROLE_COORD));
        write_reg(CFG_MAX_TTL, 32'd15);
        write_reg(CFG_CACHE_TIMEOUT, 32'd20);
      end
      4: begin
        write_reg(CFG_OWN_UID, $urandom);
        write_reg(CFG_NODE_ROLE, CFG_DATA_W'(ROLE_RELAY));
        write_reg(CFG_MAX_TTL, $urandom_range(1, 255));
        write_reg(CFG_CACHE_TIMEOUT, $urandom_range(0, 50));
      end
      default: begin
        write_reg(CFG_OWN_UID, $urandom);
        write_reg(CFG_NODE_ROLE, $urandom_range(0, 3));
        write_reg(CFG_MAX_TTL, 32'd64);
        write_reg(CFG_CACHE_TIMEOUT, 32'd30000);
      end
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_directed();
    int i;
    pending_words.push_back(pkt(1'b0, '1, '1, '1, '1, '1));
    pending_words.push_back(pkt(1'b1, '1, 16'hFFFF, my_uid, 8'd0, '1));
    pending_words.push_back(pkt(1'b1, '1, 16'hFFFF, my_uid, 8'd0, '1));
    pending_words.push_back(pkt(1'b1, 32'd1, 16'd0, BROADCAST_UID, 8'hFF, 32'd0));
    pending_words.push_back(pkt(1'b1, 32'd2, 16'd1, FOREIGN_UID, 8'hFF, 32'h0000_000A));
    pending_words.push_back(pkt(1'b1, 32'd3, 16'd2, FOREIGN_UID, 8'd1, 32'h0000_000B));
    pending_words.push_back(pkt(1'b1, 32'd4, 16'd3, FOREIGN_UID, 8'd0, 32'h0000_000C));
    pending_words.push_back(pkt(1'b1, 32'd5, 16'd4, FOREIGN_UID, 8'd2, 32'h0000_000D));
    pending_words.push_back(pkt(1'b1, 32'd0, 16'd0, FOREIGN_UID, 8'd5, 32'h0000_000E));
    pending_words.push_back(pkt(1'b1, 32'd0, 16'd0, FOREIGN_UID, 8'd5, 32'h0000_000E));
    // timeout is zero here, so one tick ages out every cached source
    pending_words.push_back(tick_word());
    pending_words.push_back(pkt(1'b1, 32'd0, 16'hFFFF, FOREIGN_UID, 8'd3, 32'd0));
    pending_words.push_back(pkt(1'b1, '1, 16'hFFFF, my_uid, 8'd9, 32'h0000_0F00));
    // push past the cache depth so the ring wraps
    for (i = 0; i < 10; i++)
      pending_words.push_back(pkt(1'b1, 32'h100 + i, SEQ_W'(i), FOREIGN_UID, 8'd8, i));
    pending_words.push_back(pkt(1'b1, 32'd1, 16'd0, BROADCAST_UID, 8'd4, 32'd0));
  endtask

  task automatic drain();
    do
      @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_verdicts.size() != 0);
    // a tick may still be walking the cache
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : run
    int p;
    int n;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    for (p = 0; p < N_PHASES; p++) begin
      program_phase(p);
      @(negedge clk);
      if (p < 2) begin
        send_gap_pct = 9;
        recv_gap_pct = 70;
      end else if (p < 4) begin
        send_gap_pct = 70;
        recv_gap_pct = 9;
      end else begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      if (p == 0)
        load_directed();
      for (n = 0; n < RAND_PER_PHASE; n++)
        pending_words.push_back(rand_word());
      drain();
    end
    if (errors == 0)
      $display("flood_relay_filter_top: match");
    else
      $display("flood_relay_filter_top: mismatch");
    $finish;
  end

endmodule
